FILE: design/vfd_pkg.sv
// Shared types and constants for the varint / fixed-field stream decoder.
// Depends on nothing; every design file refers to it by scoped names.
package vfd_pkg;

  // Value kinds, sampled from cmd on the first byte of a value
  localparam logic [1:0] KIND_VARINT32 = 2'd0;
  localparam logic [1:0] KIND_VARINT64 = 2'd1;
  localparam logic [1:0] KIND_FIXED32  = 2'd2;
  localparam logic [1:0] KIND_FIXED64  = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERLONG  = 2'd1;
  localparam logic [1:0] STATUS_LIMIT_END = 2'd2;
  localparam logic [1:0] STATUS_LIMIT_MID = 2'd3;

  // Stream limit register
  localparam logic [30:0] NO_LIMIT    = 31'h7FFF_FFFF;
  localparam logic [30:0] LIMIT_RESET = 31'(64 << 20);

  // Register index of the stream limit
  localparam logic REG_STREAM_LIMIT = 1'b0;

  // Most 7-bit groups any varint may place into the accumulator
  localparam int VARINT_GROUPS = 10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] cmd;
  } byte_word_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [1:0]  status;
    logic [3:0]  byte_count;
  } result_word_t;

endpackage

FILE: design/varint_fixed_field_decoder_top.sv
// Top level of the byte-serial varint / fixed-field stream decoder.
// Depends on vfd_pkg for the word types, kind and status codes.
//
// The decoder takes one stream byte per word and returns at most one result
// word per input word: an unsigned base-128 varint (low group first, 32- or
// 64-bit) or a little-endian fixed32 / fixed64, with the kind chosen by cmd
// on the first byte of each value. Throughput is one byte per clock while
// the result channel does not stall: a byte is captured in an input register,
// and once the result register can advance a single pass of logic ORs its
// group into the accumulator, updates the value state and, on the last byte,
// loads the result register, from which the result word is then valid. The
// byte path stalls whenever the input register is full while a result word
// waits under stall, even if the held byte closes no value.
// The stream limit (APB offset 0) refuses bytes once the stream position
// reaches it: at a value boundary the result is a clean end (status 2), mid
// value a truncation (status 3) that drops the partial value. A limit of
// 0x7FFFFFFF disables refusal. A varint whose last permitted byte still has
// its top bit set reports status 1. Write the limit only while the decoder
// is idle.
module varint_fixed_field_decoder_top #(
  parameter int MAX_VARINT_BYTES = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // byte channel
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  vfd_pkg::byte_word_t   byte_word,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output vfd_pkg::result_word_t result_word,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [3:0] MAX_BYTES = 4'(MAX_VARINT_BYTES);

  // Configuration
  logic [30:0] stream_limit;

  // Input register
  logic                q_valid;
  vfd_pkg::byte_word_t q_word;

  // Value state
  logic [63:0] accumulator;
  logic [3:0]  bytes_in_value;
  logic [1:0]  latched_kind;
  logic [30:0] stream_position;

  // Single-pass decode signals
  logic        advance;
  logic        take;
  logic        first;
  logic        refused;
  logic [1:0]  kind;
  logic [63:0] acc_base;
  logic [63:0] group;
  logic [63:0] acc_new;
  logic [3:0]  idx_inc;
  logic        emit;
  logic        done;
  vfd_pkg::result_word_t result_next;
  logic [63:0] accumulator_next;
  logic [3:0]  bytes_in_value_next;
  logic [1:0]  latched_kind_next;
  logic [30:0] stream_position_next;

  // ---------------------------------------------------------------------
  // APB register: writes take effect on the access phase
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == vfd_pkg::REG_STREAM_LIMIT) ? {1'b0, stream_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_limit <= vfd_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == vfd_pkg::REG_STREAM_LIMIT) begin
      stream_limit <= pwdata[30:0];
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the decode stage advances whenever the result register is
  // free or being drained; the input register refills as it empties.
  // ---------------------------------------------------------------------
  assign advance    = !result_valid || !result_stall;
  assign take       = q_valid && advance;
  assign byte_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!byte_stall) begin
      q_valid <= byte_valid;
    end
  end

  // Payload only; hold while stalled
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      q_word <= byte_word;
    end
  end

  // ---------------------------------------------------------------------
  // Decode pass
  // ---------------------------------------------------------------------
  assign refused  = (stream_limit != vfd_pkg::NO_LIMIT) && (stream_position >= stream_limit);
  assign first    = (bytes_in_value == 4'd0);
  assign kind     = first ? q_word.cmd : latched_kind;
  assign acc_base = first ? 64'd0 : accumulator;
  assign idx_inc  = bytes_in_value + 4'd1;

  // Place this byte's group at its offset: 7-bit groups for varints (bits
  // past 63 drop off), whole bytes for fixed values.
  always_comb begin
    group = 64'd0;
    if (!kind[1]) begin
      for (int i = 0; i < vfd_pkg::VARINT_GROUPS; i++) begin
        if (bytes_in_value == 4'(i)) begin
          group = {57'd0, q_word.data_byte[6:0]} << (7 * i);
        end
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (bytes_in_value == 4'(i)) begin
          group = {56'd0, q_word.data_byte} << (8 * i);
        end
      end
    end
  end

  assign acc_new = acc_base | group;

  always_comb begin
    emit                 = 1'b0;
    done                 = 1'b0;
    result_next          = '0;
    accumulator_next     = accumulator;
    bytes_in_value_next  = bytes_in_value;
    latched_kind_next    = latched_kind;
    stream_position_next = stream_position;
    priority if (refused) begin
      // Byte discarded with the position held: report and fall back to a value boundary
      emit                   = 1'b1;
      done                   = 1'b1;
      result_next.status     = first ? vfd_pkg::STATUS_LIMIT_END : vfd_pkg::STATUS_LIMIT_MID;
      result_next.byte_count = bytes_in_value;
    end else begin
      if (stream_position != vfd_pkg::NO_LIMIT) begin
        stream_position_next = stream_position + 31'd1;
      end
      latched_kind_next = kind;
      accumulator_next  = acc_new;
      if (!kind[1]) begin
        if (!q_word.data_byte[7]) begin
          emit                      = 1'b1;
          done                      = 1'b1;
          result_next.status        = vfd_pkg::STATUS_OK;
          result_next.byte_count    = idx_inc;
          result_next.decoded_value = (kind == vfd_pkg::KIND_VARINT32) ?
                                      {32'd0, acc_new[31:0]} : acc_new;
        end else if (idx_inc >= MAX_BYTES) begin
          emit                   = 1'b1;
          done                   = 1'b1;
          result_next.status     = vfd_pkg::STATUS_OVERLONG;
          result_next.byte_count = MAX_BYTES;
        end
      end else begin
        if (idx_inc >= ((kind == vfd_pkg::KIND_FIXED32) ? 4'd4 : 4'd8)) begin
          emit                      = 1'b1;
          done                      = 1'b1;
          result_next.status        = vfd_pkg::STATUS_OK;
          result_next.byte_count    = idx_inc;
          result_next.decoded_value = acc_new;
        end
      end
      if (!done) begin
        bytes_in_value_next = idx_inc;
      end
    end
    if (done) begin
      accumulator_next    = 64'd0;
      bytes_in_value_next = 4'd0;
    end
  end

  // ---------------------------------------------------------------------
  // Value state: advance on every consumed input word
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= 64'd0;
      bytes_in_value  <= 4'd0;
      latched_kind    <= vfd_pkg::KIND_VARINT32;
      stream_position <= 31'd0;
    end else if (take) begin
      accumulator     <= accumulator_next;
      bytes_in_value  <= bytes_in_value_next;
      latched_kind    <= latched_kind_next;
      stream_position <= stream_position_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result_word <= result_next;
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for varint_fixed_field_decoder_top.
// Depends on vfd_pkg (word types, kind and status codes, limit constants).
// Drives byte words, predicts each result word and compares at the result port.
`timescale 1ns / 100ps

module tb_top;

  localparam int          VARINT_MAX     = 10;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          HOLDOFF_CYCLES = 200;
  localparam logic [2:0]  LIMIT_ADDR     = {vfd_pkg::REG_STREAM_LIMIT, 2'b00};

  // Clock and reset; every block input starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  byte_valid   = 1'b0;
  logic                  byte_stall;
  vfd_pkg::byte_word_t   byte_word    = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  vfd_pkg::result_word_t result_word;

  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [2:0]   paddr   = '0;
  logic [31:0]  pwdata  = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Stimulus and checking state
  vfd_pkg::byte_word_t   byte_pending[$];      // byte words waiting for the driver
  vfd_pkg::result_word_t expected_results[$];  // predicted result words, oldest first
  logic         byte_fire   = 1'b0;   // byte word accepted at the last rising edge
  int unsigned  idle_pct    = 0;      // chance in 100 that the sender idles
  int unsigned  stall_pct   = 0;      // chance in 100 that the receiver stalls
  bit           pressure_on = 1'b0;
  int unsigned  holdoff_cnt = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  fail_count  = 0;

  // Predictor state: a private copy of the decoder's value state and limit
  logic [63:0]  value_acc  = '0;
  logic [3:0]   value_len  = '0;
  logic [1:0]   value_kind = vfd_pkg::KIND_VARINT32;
  logic [30:0]  stream_pos = '0;
  logic [30:0]  limit_cfg  = vfd_pkg::LIMIT_RESET;

  varint_fixed_field_decoder_top #(
    .MAX_VARINT_BYTES(VARINT_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word (result_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  // Advance the predicted decoder by one accepted byte word. Return 1 and fill
  // res when that byte closes a value, is refused, or ends an overlong varint.
  function automatic bit decode_byte(input vfd_pkg::byte_word_t w,
                                     output vfd_pkg::result_word_t res);
    int unsigned idx;
    logic [63:0] v;
    res = '0;
    // Refused byte: the position stays, and any partial value is dropped.
    if (limit_cfg != vfd_pkg::NO_LIMIT && stream_pos >= limit_cfg) begin
      res.status     = (value_len == 0) ? vfd_pkg::STATUS_LIMIT_END :
                                          vfd_pkg::STATUS_LIMIT_MID;
      res.byte_count = value_len;
      value_acc = '0;
      value_len = '0;
      return 1'b1;
    end
    // Position saturates once it reaches the no-limit code.
    if (stream_pos != vfd_pkg::NO_LIMIT) stream_pos = stream_pos + 31'd1;
    // Latch the kind on the first byte of a value only.
    if (value_len == 0) begin
      value_kind = w.cmd;
      value_acc  = '0;
    end
    idx = value_len;
    if (value_kind == vfd_pkg::KIND_VARINT32 || value_kind == vfd_pkg::KIND_VARINT64) begin
      // Groups past bit 63 fall off the shift.
      if (idx < 10) value_acc = value_acc | (64'(w.data_byte[6:0]) << (7 * idx));
      if (!w.data_byte[7]) begin
        v = value_acc;
        if (value_kind == vfd_pkg::KIND_VARINT32) v[63:32] = '0;
        res.decoded_value = v;
        res.status        = vfd_pkg::STATUS_OK;
        res.byte_count    = 4'(idx + 1);
        value_acc = '0;
        value_len = '0;
        return 1'b1;
      end
      // Overlong varint: last permitted byte still asks for more.
      if (idx + 1 >= VARINT_MAX) begin
        res.status     = vfd_pkg::STATUS_OVERLONG;
        res.byte_count = 4'(VARINT_MAX);
        value_acc = '0;
        value_len = '0;
        return 1'b1;
      end
      value_len = 4'(idx + 1);
      return 1'b0;
    end
    // Fixed kinds: little-endian bytes.
    if (idx < 8) value_acc = value_acc | (64'(w.data_byte) << (8 * idx));
    if (idx + 1 >= ((value_kind == vfd_pkg::KIND_FIXED32) ? 4 : 8)) begin
      res.decoded_value = value_acc;
      res.status        = vfd_pkg::STATUS_OK;
      res.byte_count    = 4'(idx + 1);
      value_acc = '0;
      value_len = '0;
      return 1'b1;
    end
    value_len = 4'(idx + 1);
    return 1'b0;
  endfunction

  // Byte driver: change words at the falling edge; hold a word until taken.
  // Valid is decided from the pending queue and the idle chance, never stall.
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_word  <= '0;
    end else if (!byte_valid || byte_fire) begin
      if (byte_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        byte_word  <= byte_pending.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off in the pressure
  // phase so the decoder backs up and stalls its byte input.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (pressure_on && holdoff_cnt < HOLDOFF_CYCLES) begin
      result_stall <= 1'b1;
      holdoff_cnt  <= holdoff_cnt + 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: sample both handshakes at the rising edge. Check the result word
  // against the oldest prediction, then predict for the byte word taken.
  always @(posedge clk) begin
    vfd_pkg::result_word_t want;
    vfd_pkg::result_word_t pred;
    if (rst) begin
      byte_fire <= 1'b0;
    end else begin
      byte_fire <= byte_valid && !byte_stall;
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d count %0d",
                                    result_word.decoded_value, result_word.status,
                                    result_word.byte_count));
        end else begin
          want = expected_results.pop_front();
          if (result_word.decoded_value !== want.decoded_value ||
              result_word.status !== want.status ||
              result_word.byte_count !== want.byte_count) begin
            report_mismatch($sformatf(
              "result value %h/%h status %0d/%0d count %0d/%0d (got/exp)",
              result_word.decoded_value, want.decoded_value, result_word.status,
              want.status, result_word.byte_count, want.byte_count));
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        if (decode_byte(byte_word, pred)) expected_results.push_back(pred);
      end
    end
  end

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** varint_fixed_field_decoder_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic [1:0] kind);
    vfd_pkg::byte_word_t w;
    w.data_byte = data;
    w.cmd       = kind;
    byte_pending.push_back(w);
  endtask

  // Queue one varint of len bytes with random groups; cmd only counts on the
  // first byte. Leave the last continuation bit set to make it overlong.
  task automatic push_varint(input logic [1:0] kind, input int unsigned len,
                             input bit terminated);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte({(i + 1 < len) || !terminated, 7'($urandom)},
                (i == 0) ? kind : 2'($urandom));
    end
  endtask

  task automatic push_fixed(input logic [1:0] kind);
    int unsigned len;
    len = (kind == vfd_pkg::KIND_FIXED32) ? 4 : 8;
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(8'($urandom), (i == 0) ? kind : 2'($urandom));
    end
  endtask

  // Mostly well-formed values with random content; the rest loose noise
  // bytes that knock the stream out of step.
  task automatic queue_values(input int n);
    int          start;
    int unsigned pick;
    logic [1:0]  kind;
    start = byte_pending.size();
    while (byte_pending.size() - start < n) begin
      pick = $urandom_range(99);
      kind = 2'($urandom_range(3));
      if (pick >= 85) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 2'($urandom));
      end else if (kind == vfd_pkg::KIND_FIXED32 || kind == vfd_pkg::KIND_FIXED64) begin
        push_fixed(kind);
      end else if (pick < 8) begin
        push_varint(kind, VARINT_MAX, 1'b0);
      end else begin
        push_varint(kind, $urandom_range(1, VARINT_MAX), 1'b1);
      end
    end
  endtask

  // Wait until the driver is empty and every prediction has been met, then
  // let the pipeline settle so a write never lands on a byte in flight.
  task automatic wait_idle();
    while (byte_pending.size() != 0 || byte_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_limit_readback(input logic [30:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[30:0] !== want) begin
      report_mismatch($sformatf("stream limit read %h, want %h", prdata[30:0], want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Setup then access cycle; the register takes the value at the access edge.
  task automatic write_limit(input logic [30:0] lim);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {1'b0, lim};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_cfg = lim;
    check_limit_readback(lim);
  endtask

  task automatic run_phase(input logic [30:0] lim, input int unsigned send_idle,
                           input int unsigned recv_stall, input int n, input bit squeeze);
    write_limit(lim);
    @(posedge clk);
    idle_pct    = send_idle;
    stall_pct   = recv_stall;
    pressure_on = squeeze;
    queue_values(n);
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_limit_readback(vfd_pkg::LIMIT_RESET);

    // Directed: zero, a full-length varint32 that keeps only 32 bits,
    // an overlong varint64, and an all-ones fixed32.
    write_limit(vfd_pkg::NO_LIMIT);
    push_byte(8'h00, vfd_pkg::KIND_VARINT32);
    for (int i = 0; i < VARINT_MAX - 1; i++) begin
      push_byte(8'hFF, (i == 0) ? vfd_pkg::KIND_VARINT32 : vfd_pkg::KIND_FIXED64);
    end
    push_byte(8'h7F, vfd_pkg::KIND_FIXED32);
    for (int i = 0; i < VARINT_MAX; i++) begin
      push_byte(8'h80, (i == 0) ? vfd_pkg::KIND_VARINT64 : vfd_pkg::KIND_VARINT32);
    end
    for (int i = 0; i < 4; i++) begin
      push_byte(8'hFF, (i == 0) ? vfd_pkg::KIND_FIXED32 : vfd_pkg::KIND_VARINT64);
    end
    wait_idle();

    // Directed: limit two bytes ahead, truncate a fixed64 mid value, then
    // refuse at the boundary.
    write_limit(stream_pos + 31'd2);
    push_byte(8'h11, vfd_pkg::KIND_FIXED64);
    push_byte(8'h22, vfd_pkg::KIND_VARINT32);
    push_byte(8'h33, vfd_pkg::KIND_FIXED32);
    push_byte(8'h44, vfd_pkg::KIND_VARINT64);
    wait_idle();

    // Random phases over idle and stall mixes, limit settings and one back-pressure phase.
    run_phase(vfd_pkg::NO_LIMIT, 0, 0, 80, 1'b0);
    run_phase(vfd_pkg::LIMIT_RESET, 86, 0, 70, 1'b0);
    run_phase(stream_pos + 31'($urandom_range(30, 60)), 0, 86, 70, 1'b0);
    run_phase(31'd0, 29, 29, 30, 1'b0);
    run_phase(vfd_pkg::NO_LIMIT, 0, 0, 80, 1'b1);
    run_phase(stream_pos + 31'($urandom_range(1, 40)), 29, 29, 70, 1'b0);

    if (fail_count == 0) begin
      $display("** varint_fixed_field_decoder_top: PASSED **");
    end else begin
      $display("** varint_fixed_field_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
design/vfd_pkg.sv
design/varint_fixed_field_decoder_top.sv
dv/tb_top.sv
